>>> design/fpf_pkg.sv
// shared types, codes and defaults for the five-stage pipeline block
`default_nettype none
package fpf_pkg;

    localparam int FPF_INSTR_WORDS = 64;
    localparam int FPF_REG_COUNT   = 32;
    localparam int FPF_DATA_WORDS  = 32;

    localparam logic [1:0] KIND_LD_INSTR = 2'd0;
    localparam logic [1:0] KIND_LD_REG   = 2'd1;
    localparam logic [1:0] KIND_LD_DATA  = 2'd2;
    localparam logic [1:0] KIND_TICK     = 2'd3;

    localparam logic [5:0] OPC_RTYPE = 6'b000000;
    localparam logic [5:0] OPC_LW    = 6'b100011;
    localparam logic [5:0] OPC_SW    = 6'b101011;
    localparam logic [5:0] OPC_ADDI  = 6'b001000;
    localparam logic [5:0] OPC_ANDI  = 6'b001100;
    localparam logic [5:0] OPC_BNE   = 6'b000101;
    localparam logic [5:0] FN_ADD    = 6'b100000;
    localparam logic [5:0] FN_AND    = 6'b100100;
    localparam logic [5:0] FN_OR     = 6'b100101;
    localparam logic [5:0] FN_SUB    = 6'b100010;
    localparam logic [5:0] FN_SLT    = 6'b101010;

    typedef enum logic [3:0] {
        ALU_ADD, ALU_SUB, ALU_AND, ALU_OR, ALU_SLT,
        ALU_ADDI, ALU_ANDI, ALU_LW, ALU_SW, ALU_BNE
    } alu_op_t;

    typedef struct packed {
        logic [7:0]  fetch_pc;
        logic        reg_write_valid;
        logic [4:0]  reg_write_index;
        logic [31:0] reg_write_value;
        logic        mem_write_valid;
        logic [4:0]  mem_write_index;
        logic [31:0] mem_write_value;
        logic        stalled;
        logic        flushed;
        logic        pipeline_empty;
    } res_t;

endpackage
`default_nettype wire

>>> design/five_stage_pipeline_forwarding_top.sv
// top level: input register, pipeline core and result queue
//  channel | direction | payload
//  s_      | in        | kind, load_index, instr_word, load_value
//  m_      | out       | fetch pc, register and memory writes, stall, flush, empty
// an item is registered in the input register on transfer and processed by the core from there
// a tick result is written into the result queue and offered on m_ from the queue
// one item per cycle sustained while the result queue is not full; a tick is one pipeline clock of the core
// load items produce no result; ticks hold in the input register while the queue is full
// reset clears pc, stage valid bits and store valid bits at once, no sweep
`default_nettype none
module five_stage_pipeline_forwarding_top #(
    parameter int INSTR_WORDS = fpf_pkg::FPF_INSTR_WORDS,
    parameter int REG_COUNT   = fpf_pkg::FPF_REG_COUNT,
    parameter int DATA_WORDS  = fpf_pkg::FPF_DATA_WORDS
) (
    input  wire logic               aclk,
    input  wire logic               aresetn,
    input  wire logic               s_valid,
    output logic                    s_ready,
    input  wire logic [1:0]         s_kind,
    input  wire logic [5:0]         s_load_index,
    input  wire logic [31:0]        s_instr_word,
    input  wire logic signed [31:0] s_load_value,
    output logic                    m_valid,
    input  wire logic               m_ready,
    output logic [7:0]              m_fetch_pc,
    output logic                    m_reg_write_valid,
    output logic [4:0]              m_reg_write_index,
    output logic signed [31:0]      m_reg_write_value,
    output logic                    m_mem_write_valid,
    output logic [4:0]              m_mem_write_index,
    output logic signed [31:0]      m_mem_write_value,
    output logic                    m_stalled,
    output logic                    m_flushed,
    output logic                    m_pipeline_empty
);
    import fpf_pkg::*;

    logic        in_v_reg;
    logic [1:0]  in_kind_reg;
    logic [5:0]  in_idx_reg;
    logic [31:0] in_ins_reg, in_val_reg;
    logic        q_space, adv;
    res_t        core_res, q_res;

    assign adv = in_v_reg && ((in_kind_reg != KIND_TICK) || q_space);
    assign s_ready = !in_v_reg || adv;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_v_reg <= 1'b0;
        end else if (s_ready) begin
            in_v_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            in_kind_reg <= s_kind;
            in_idx_reg <= s_load_index;
            in_ins_reg <= s_instr_word;
            in_val_reg <= s_load_value;
        end
    end

    fpf_core #(
        .INSTR_WORDS(INSTR_WORDS),
        .REG_COUNT(REG_COUNT),
        .DATA_WORDS(DATA_WORDS)
    ) u_core (
        .aclk(aclk),
        .aresetn(aresetn),
        .en(adv),
        .kind(in_kind_reg),
        .load_index(in_idx_reg),
        .instr_word(in_ins_reg),
        .load_value(in_val_reg),
        .res(core_res)
    );

    fpf_outq u_outq (
        .aclk(aclk),
        .aresetn(aresetn),
        .push(adv && (in_kind_reg == KIND_TICK)),
        .push_data(core_res),
        .space(q_space),
        .out_valid(m_valid),
        .out_ready(m_ready),
        .out_data(q_res)
    );

    assign m_fetch_pc = q_res.fetch_pc;
    assign m_reg_write_valid = q_res.reg_write_valid;
    assign m_reg_write_index = q_res.reg_write_index;
    assign m_reg_write_value = q_res.reg_write_value;
    assign m_mem_write_valid = q_res.mem_write_valid;
    assign m_mem_write_index = q_res.mem_write_index;
    assign m_mem_write_value = q_res.mem_write_value;
    assign m_stalled = q_res.stalled;
    assign m_flushed = q_res.flushed;
    assign m_pipeline_empty = q_res.pipeline_empty;

endmodule
`default_nettype wire

>>> design/fpf_core.sv
// pipeline registers, stores, forwarding and hazard logic, one tick per enable with kind tick
`default_nettype none
module fpf_core #(
    parameter int INSTR_WORDS = fpf_pkg::FPF_INSTR_WORDS,
    parameter int REG_COUNT   = fpf_pkg::FPF_REG_COUNT,
    parameter int DATA_WORDS  = fpf_pkg::FPF_DATA_WORDS
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        en,
    input  wire logic [1:0]  kind,
    input  wire logic [5:0]  load_index,
    input  wire logic [31:0] instr_word,
    input  wire logic [31:0] load_value,
    output fpf_pkg::res_t    res
);
    import fpf_pkg::*;

    localparam int IW = (INSTR_WORDS > 1) ? $clog2(INSTR_WORDS) : 1;
    localparam int RW = $clog2(REG_COUNT);
    localparam int DW = $clog2(DATA_WORDS);

    logic [31:0] istore [INSTR_WORDS];
    logic [INSTR_WORDS-1:0] ipres_reg;
    logic [31:0] rf_mem [REG_COUNT];
    logic [REG_COUNT-1:0] rf_vld_reg;
    logic [31:0] dmem [DATA_WORDS];
    logic [DATA_WORDS-1:0] dm_vld_reg;

    logic [7:0]  pc_reg, pc_next;
    logic        fd_v_reg, fd_v_next;
    logic [31:0] fd_ins_reg;
    logic [7:0]  fd_pc4_reg;
    logic        de_v_reg, de_v_next;
    alu_op_t     de_op_reg;
    logic [4:0]  de_rs_reg, de_rt_reg, de_dest_reg;
    logic [31:0] de_a_reg, de_b_reg, de_imm_reg;
    logic [7:0]  de_pc4_reg;
    logic        de_wr_reg;
    logic        em_v_reg, em_wr_reg, em_ld_reg, em_st_reg;
    logic [4:0]  em_dest_reg;
    logic [31:0] em_alu_reg, em_sv_reg;
    logic        mw_v_reg, mw_wr_reg;
    logic [4:0]  mw_dest_reg;
    logic [31:0] mw_val_reg;

    logic        tick, ld_i, ld_r, ld_d;
    logic [31:0] li_ext, slot_ext;
    logic [IW-1:0] slot_idx, li_idx;
    logic [DW-1:0] ld_di;
    logic        fetched, fetch_take;

    assign tick = en && (kind == KIND_TICK);
    assign li_ext = 32'(load_index);
    assign li_idx = li_ext[IW-1:0];
    assign ld_di = li_ext[DW-1:0];
    assign ld_i = en && (kind == KIND_LD_INSTR) && (li_ext < INSTR_WORDS);
    assign ld_r = en && (kind == KIND_LD_REG) && (load_index != 6'd0) && (li_ext < REG_COUNT);
    assign ld_d = en && (kind == KIND_LD_DATA) && (li_ext < DATA_WORDS);
    assign slot_ext = 32'(pc_reg[7:2]);
    assign slot_idx = slot_ext[IW-1:0];
    assign fetched = (slot_ext < INSTR_WORDS) && ipres_reg[slot_idx];

    // writeback
    logic wb_we;
    assign wb_we = mw_v_reg && mw_wr_reg && (mw_dest_reg != 5'd0) &&
                   (32'(mw_dest_reg) < REG_COUNT);

    // memory
    logic [DW-1:0] wi;
    logic [31:0]   wi_ext;
    assign wi = em_alu_reg[DW+1:2];
    assign wi_ext = 32'(wi);

    // execute
    function automatic logic [31:0] fwd(input logic [4:0] r, input logic [31:0] rd,
                                        input logic ev, input logic ew, input logic el,
                                        input logic [4:0] ed, input logic [31:0] ea,
                                        input logic mv, input logic mwr,
                                        input logic [4:0] md, input logic [31:0] mval);
        logic [31:0] v;
        if (r == 5'd0) v = '0;
        else if (ev && ew && !el && ed == r) v = ea;
        else if (mv && mwr && md == r) v = mval;
        else v = rd;
        return v;
    endfunction

    logic [31:0] ex_a, ex_b, ex_r;
    logic        taken;
    logic [7:0]  target;
    assign ex_a = fwd(de_rs_reg, de_a_reg, em_v_reg, em_wr_reg, em_ld_reg, em_dest_reg,
                      em_alu_reg, mw_v_reg, mw_wr_reg, mw_dest_reg, mw_val_reg);
    assign ex_b = fwd(de_rt_reg, de_b_reg, em_v_reg, em_wr_reg, em_ld_reg, em_dest_reg,
                      em_alu_reg, mw_v_reg, mw_wr_reg, mw_dest_reg, mw_val_reg);

    always_comb begin
        case (de_op_reg)
            ALU_ADD:  ex_r = ex_a + ex_b;
            ALU_SUB:  ex_r = ex_a - ex_b;
            ALU_AND:  ex_r = ex_a & ex_b;
            ALU_OR:   ex_r = ex_a | ex_b;
            ALU_SLT:  ex_r = {31'd0, $signed(ex_a) < $signed(ex_b)};
            ALU_ANDI: ex_r = ex_a & de_imm_reg;
            ALU_BNE:  ex_r = ex_a - ex_b;
            default:  ex_r = ex_a + de_imm_reg;
        endcase
    end
    assign taken = de_v_reg && (de_op_reg == ALU_BNE) && (ex_a != ex_b);
    assign target = de_pc4_reg + {de_imm_reg[5:0], 2'b00};

    // decode
    logic [5:0]  opc, fn;
    logic [4:0]  d_rs, d_rt, d_rd, d_dest;
    logic        d_v, d_wr;
    alu_op_t     d_op;
    logic [31:0] d_imm;
    logic        stall;
    assign opc = fd_ins_reg[31:26];
    assign fn = fd_ins_reg[5:0];
    assign d_rs = fd_ins_reg[25:21];
    assign d_rt = fd_ins_reg[20:16];
    assign d_rd = fd_ins_reg[15:11];

    always_comb begin
        d_v = fd_v_reg;
        d_wr = 1'b0;
        d_dest = '0;
        d_op = ALU_ADD;
        d_imm = {{16{fd_ins_reg[15]}}, fd_ins_reg[15:0]};
        case (opc)
            OPC_RTYPE: begin
                d_dest = d_rd;
                d_wr = 1'b1;
                case (fn)
                    FN_ADD:  d_op = ALU_ADD;
                    FN_SUB:  d_op = ALU_SUB;
                    FN_AND:  d_op = ALU_AND;
                    FN_OR:   d_op = ALU_OR;
                    FN_SLT:  d_op = ALU_SLT;
                    default: d_v = 1'b0;
                endcase
            end
            OPC_LW: begin
                d_op = ALU_LW;
                d_dest = d_rt;
                d_wr = 1'b1;
            end
            OPC_SW:   d_op = ALU_SW;
            OPC_ADDI: begin
                d_op = ALU_ADDI;
                d_dest = d_rt;
                d_wr = 1'b1;
            end
            OPC_ANDI: begin
                d_op = ALU_ANDI;
                d_dest = d_rt;
                d_wr = 1'b1;
                d_imm = {16'd0, fd_ins_reg[15:0]};
            end
            OPC_BNE:  d_op = ALU_BNE;
            default:  d_v = 1'b0;
        endcase
    end

    assign stall = fd_v_reg && de_v_reg && (de_op_reg == ALU_LW) && (de_dest_reg != 5'd0) &&
                   ((de_dest_reg == d_rs) || (de_dest_reg == d_rt));

    assign fetch_take = !taken && !stall;

    always_comb begin
        if (taken) begin
            pc_next = target;
            fd_v_next = 1'b0;
            de_v_next = 1'b0;
        end else if (stall) begin
            pc_next = pc_reg;
            fd_v_next = fd_v_reg;
            de_v_next = 1'b0;
        end else begin
            pc_next = pc_reg + 8'd4;
            fd_v_next = fetched;
            de_v_next = d_v;
        end
    end

    // register read ports see this tick's writeback
    logic        rs_ok, rt_ok, rs_byp, rt_byp;
    logic [RW-1:0] rs_i, rt_i, wb_i, lr_i;
    assign rs_i = d_rs[RW-1:0];
    assign rt_i = d_rt[RW-1:0];
    assign wb_i = mw_dest_reg[RW-1:0];
    assign lr_i = load_index[RW-1:0];
    assign rs_byp = wb_we && (mw_dest_reg == d_rs);
    assign rt_byp = wb_we && (mw_dest_reg == d_rt);
    assign rs_ok = (d_rs != 5'd0) && (32'(d_rs) < REG_COUNT) && rf_vld_reg[rs_i];
    assign rt_ok = (d_rt != 5'd0) && (32'(d_rt) < REG_COUNT) && rf_vld_reg[rt_i];

    always_ff @(posedge aclk) begin
        if (ld_i) begin
            istore[li_idx] <= instr_word;
        end
        if (tick && fetch_take) begin
            fd_ins_reg <= istore[slot_idx];
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_r) begin
            rf_mem[lr_i] <= load_value;
        end else if (tick && wb_we) begin
            rf_mem[wb_i] <= mw_val_reg;
        end
        if (tick) begin
            if (rs_byp) de_a_reg <= mw_val_reg;
            else if (rs_ok) de_a_reg <= rf_mem[rs_i];
            else de_a_reg <= '0;
            if (rt_byp) de_b_reg <= mw_val_reg;
            else if (rt_ok) de_b_reg <= rf_mem[rt_i];
            else de_b_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (ld_d) begin
            dmem[ld_di] <= load_value;
        end else if (tick && em_v_reg && em_st_reg) begin
            dmem[wi] <= em_sv_reg;
        end
        if (tick) begin
            if (!em_ld_reg) mw_val_reg <= em_alu_reg;
            else if (dm_vld_reg[wi]) mw_val_reg <= dmem[wi];
            else mw_val_reg <= '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            ipres_reg <= '0;
            rf_vld_reg <= '0;
            dm_vld_reg <= '0;
            pc_reg <= '0;
            fd_v_reg <= 1'b0;
            de_v_reg <= 1'b0;
            em_v_reg <= 1'b0;
            mw_v_reg <= 1'b0;
        end else begin
            if (ld_i) ipres_reg[li_idx] <= 1'b1;
            if (ld_r) rf_vld_reg[lr_i] <= 1'b1;
            else if (tick && wb_we) rf_vld_reg[wb_i] <= 1'b1;
            if (ld_d) dm_vld_reg[ld_di] <= 1'b1;
            else if (tick && em_v_reg && em_st_reg) dm_vld_reg[wi] <= 1'b1;
            if (tick) begin
                pc_reg <= pc_next;
                fd_v_reg <= fd_v_next;
                de_v_reg <= de_v_next;
                em_v_reg <= de_v_reg;
                mw_v_reg <= em_v_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (tick) begin
            if (fetch_take) fd_pc4_reg <= pc_reg + 8'd4;
            de_op_reg <= d_op;
            de_rs_reg <= d_rs;
            de_rt_reg <= d_rt;
            de_dest_reg <= d_dest;
            de_imm_reg <= d_imm;
            de_pc4_reg <= fd_pc4_reg;
            de_wr_reg <= d_wr;
            em_wr_reg <= de_wr_reg;
            em_ld_reg <= de_v_reg && (de_op_reg == ALU_LW);
            em_st_reg <= de_v_reg && (de_op_reg == ALU_SW);
            em_dest_reg <= de_dest_reg;
            em_alu_reg <= ex_r;
            em_sv_reg <= ex_b;
            mw_wr_reg <= em_wr_reg;
            mw_dest_reg <= em_dest_reg;
        end
    end

    always_comb begin
        res.fetch_pc = pc_reg;
        res.reg_write_valid = wb_we;
        res.reg_write_index = wb_we ? mw_dest_reg : 5'd0;
        res.reg_write_value = wb_we ? mw_val_reg : 32'd0;
        res.mem_write_valid = em_v_reg && em_st_reg;
        res.mem_write_index = (em_v_reg && em_st_reg) ? wi_ext[4:0] : 5'd0;
        res.mem_write_value = (em_v_reg && em_st_reg) ? em_sv_reg : 32'd0;
        res.stalled = !taken && stall;
        res.flushed = taken;
        res.pipeline_empty = !fd_v_next && !de_v_next && !de_v_reg && !em_v_reg;
    end

endmodule
`default_nettype wire

>>> design/fpf_outq.sv
// two-entry result queue between the pipeline and the result channel
`default_nettype none
module fpf_outq (
    input  wire logic     aclk,
    input  wire logic     aresetn,
    input  wire logic     push,
    input  fpf_pkg::res_t push_data,
    output logic          space,
    output logic          out_valid,
    input  wire logic     out_ready,
    output fpf_pkg::res_t out_data
);
    import fpf_pkg::*;

    res_t       buf_reg [2];
    logic [1:0] cnt_reg, cnt_next;
    logic       wp_reg, rp_reg;
    logic       pop;

    assign space = (cnt_reg != 2'd2);
    assign out_valid = (cnt_reg != 2'd0);
    assign out_data = buf_reg[rp_reg];
    assign pop = out_valid && out_ready;

    always_comb begin
        cnt_next = cnt_reg;
        if (push && !pop) cnt_next = cnt_reg + 2'd1;
        else if (pop && !push) cnt_next = cnt_reg - 2'd1;
    end

    always_ff @(posedge aclk) begin
        if (push) buf_reg[wp_reg] <= push_data;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
            wp_reg <= 1'b0;
            rp_reg <= 1'b0;
        end else begin
            cnt_reg <= cnt_next;
            if (push) wp_reg <= !wp_reg;
            if (pop) rp_reg <= !rp_reg;
        end
    end

endmodule
`default_nettype wire

>>> design/fpf_checker.sv
// port-level checks on the result channel and their bind to the top level
`default_nettype none
module fpf_checker (
    input wire logic        aclk,
    input wire logic        aresetn,
    input wire logic        m_valid,
    input wire logic        m_ready,
    input wire logic [7:0]  m_fetch_pc,
    input wire logic        m_reg_write_valid,
    input wire logic [4:0]  m_reg_write_index,
    input wire logic [31:0] m_reg_write_value,
    input wire logic        m_mem_write_valid,
    input wire logic [4:0]  m_mem_write_index,
    input wire logic [31:0] m_mem_write_value,
    input wire logic        m_stalled,
    input wire logic        m_flushed
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_fetch_pc))
        else $error("result changed while stalled");

    a_excl: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> !(m_stalled && m_flushed))
        else $error("stall and flush together");

    a_rw_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_reg_write_valid |-> m_reg_write_index == 5'd0 &&
        m_reg_write_value == 32'd0)
        else $error("register write fields not cleared");

    a_rw_nz: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_reg_write_valid |-> m_reg_write_index != 5'd0)
        else $error("write to register zero reported");

    a_mw_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_mem_write_valid |-> m_mem_write_index == 5'd0 &&
        m_mem_write_value == 32'd0)
        else $error("memory write fields not cleared");

endmodule

bind five_stage_pipeline_forwarding_top fpf_checker u_fpf_checker (
    .aclk(aclk),
    .aresetn(aresetn),
    .m_valid(m_valid),
    .m_ready(m_ready),
    .m_fetch_pc(m_fetch_pc),
    .m_reg_write_valid(m_reg_write_valid),
    .m_reg_write_index(m_reg_write_index),
    .m_reg_write_value(m_reg_write_value),
    .m_mem_write_valid(m_mem_write_valid),
    .m_mem_write_index(m_mem_write_index),
    .m_mem_write_value(m_mem_write_value),
    .m_stalled(m_stalled),
    .m_flushed(m_flushed)
);
`default_nettype wire
